// ===== src/pdc_pkg.sv =====
// ----------------------------------------------------------------------------
// pdc_pkg
// Shared types and constants for the PID duty controller: default widths,
// register map of the configuration port and register reset values.
// ----------------------------------------------------------------------------
package pdc_pkg;

  // default parameter values
  localparam int ERROR_BITS_DEF     = 12;
  localparam int INTEGRAL_BITS_DEF  = 24;
  localparam int GAIN_FRAC_BITS_DEF = 12;

  // fixed field widths
  localparam int GAIN_W     = 16;
  localparam int DUTY_W     = 7;
  localparam int CFG_IDX_W  = 3;
  localparam int CFG_DATA_W = 16;

  typedef logic [GAIN_W-1:0] gain_t;
  typedef logic [DUTY_W-1:0] duty_t;

  // configuration register map
  typedef enum logic [CFG_IDX_W-1:0] {
    REG_PROP_GAIN    = 3'd0,
    REG_INTEG_GAIN   = 3'd1,
    REG_DERIV_GAIN   = 3'd2,
    REG_HOVER_OFFSET = 3'd3,
    REG_DUTY_FLOOR   = 3'd4,
    REG_DUTY_CEILING = 3'd5
  } cfg_reg_t;

  // register reset values
  localparam gain_t PROP_GAIN_RST    = 16'd7373;
  localparam gain_t INTEG_GAIN_RST   = 16'd41;
  localparam gain_t DERIV_GAIN_RST   = 16'd0;
  localparam duty_t HOVER_OFFSET_RST = 7'd50;
  localparam duty_t DUTY_FLOOR_RST   = 7'd10;
  localparam duty_t DUTY_CEILING_RST = 7'd90;

endpackage

// ===== src/pdc_in_if.sv =====
// ----------------------------------------------------------------------------
// pdc_in_if
// Error sample channel: valid/ready handshake with a signed error payload.
// ----------------------------------------------------------------------------
interface pdc_in_if
  import pdc_pkg::*;
#(
  parameter int ERROR_BITS = ERROR_BITS_DEF
);
  logic                         valid;
  logic                         ready;
  logic signed [ERROR_BITS-1:0] error_sample;

  modport source (output valid, output error_sample, input ready);
  modport sink   (input valid, input error_sample, output ready);
endinterface

// ===== src/pdc_out_if.sv =====
// ----------------------------------------------------------------------------
// pdc_out_if
// Duty result channel: valid/ready handshake with duty and clamp flag.
// ----------------------------------------------------------------------------
interface pdc_out_if
  import pdc_pkg::*;
();
  logic  valid;
  logic  ready;
  duty_t duty_percent;
  logic  was_clamped;

  modport source (output valid, output duty_percent, output was_clamped, input ready);
  modport sink   (input valid, input duty_percent, input was_clamped, output ready);
endinterface

// ===== src/pid_duty_controller_unit.sv =====
// ----------------------------------------------------------------------------
// pid_duty_controller_unit
// PID controller with saturating integral and clamped duty output.
// ----------------------------------------------------------------------------
// Usage:
//   in_ch  : one signed error sample per transfer (target minus measured)
//   out_ch : one duty value in percent per sample, plus a clamp flag
//   cfg_*  : write-only register port (gains, hover offset, duty limits),
//            written while the block is idle
// Path: a sample transfer loads the input register; the PID sum,
//   truncation and clamp then load the output register, from which the
//   result transfers to out_ch.
// Throughput: one sample per cycle unless out_ch stalls; the integral
//   and previous error update in the same cycle as the output register.
// Reset (rst_n low at a clock edge): both channels empty, integral and
//   previous error cleared, registers back to their defaults.
// Receiver stall: the result holds in the output register and one more
//   sample is taken into the input register; then in_ch.ready drops until
//   the result transfers.
// ----------------------------------------------------------------------------
module pid_duty_controller_unit
  import pdc_pkg::*;
#(
  parameter int ERROR_BITS     = ERROR_BITS_DEF,
  parameter int INTEGRAL_BITS  = INTEGRAL_BITS_DEF,
  parameter int GAIN_FRAC_BITS = GAIN_FRAC_BITS_DEF
) (
  input  logic                  clk,
  input  logic                  rst_n,
  pdc_in_if.sink                in_ch,
  pdc_out_if.source             out_ch,
  input  logic                  cfg_wr_en,
  input  logic [CFG_IDX_W-1:0]  cfg_index,
  input  logic [CFG_DATA_W-1:0] cfg_wdata
);

  localparam int IW  = (INTEGRAL_BITS > ERROR_BITS ? INTEGRAL_BITS : ERROR_BITS) + 1;
  localparam int DW  = ERROR_BITS + 1;
  localparam int PW  = GAIN_W + 1 + ERROR_BITS;
  localparam int IPW = GAIN_W + 1 + INTEGRAL_BITS;
  localparam int DPW = GAIN_W + 1 + DW;
  localparam int SW  = (IPW > DPW ? IPW : DPW) + 2;

  localparam logic signed [IW-1:0] INTEG_MAX =
    IW'((longint'(1) << (INTEGRAL_BITS - 1)) - 1);
  localparam logic signed [IW-1:0] INTEG_MIN = -INTEG_MAX - IW'(1);
  localparam logic signed [SW-1:0] FRAC_MASK =
    SW'((longint'(1) << GAIN_FRAC_BITS) - 1);

  // configuration registers
  gain_t prop_gain_r, integ_gain_r, deriv_gain_r;
  duty_t hover_r, floor_r, ceil_r;

  // controller state
  logic signed [INTEGRAL_BITS-1:0] integral_r, integral_nxt;
  logic signed [ERROR_BITS-1:0]    last_err_r;

  // input register
  logic                         s1_valid_r;
  logic signed [ERROR_BITS-1:0] s1_err_r;

  // output register
  logic  out_valid_r;
  duty_t out_duty_r, out_duty_nxt;
  logic  out_clamped_r, out_clamped_nxt;

  logic advance;

  logic signed [IW-1:0]  integ_sum;
  logic signed [IW-1:0]  integ_sat;
  logic signed [DW-1:0]  deriv;
  logic signed [PW-1:0]  p_prod;
  logic signed [IPW-1:0] i_prod;
  logic signed [DPW-1:0] d_prod;
  logic signed [SW-1:0]  pid_sum;
  logic signed [SW-1:0]  sum_adj;
  logic signed [SW-1:0]  pid_int;
  logic signed [SW-1:0]  raw_duty;
  logic signed [SW-1:0]  floor_ext;
  logic signed [SW-1:0]  ceil_ext;

  // handshake
  assign advance      = s1_valid_r && (!out_valid_r || out_ch.ready);
  assign in_ch.ready  = !s1_valid_r || advance;
  assign out_ch.valid = out_valid_r;
  assign out_ch.duty_percent = out_duty_r;
  assign out_ch.was_clamped  = out_clamped_r;

  // configuration writes, unknown index ignored
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      prop_gain_r  <= PROP_GAIN_RST;
      integ_gain_r <= INTEG_GAIN_RST;
      deriv_gain_r <= DERIV_GAIN_RST;
      hover_r      <= HOVER_OFFSET_RST;
      floor_r      <= DUTY_FLOOR_RST;
      ceil_r       <= DUTY_CEILING_RST;
    end else if (cfg_wr_en) begin
      unique case (cfg_reg_t'(cfg_index))
        REG_PROP_GAIN:    prop_gain_r  <= cfg_wdata[GAIN_W-1:0];
        REG_INTEG_GAIN:   integ_gain_r <= cfg_wdata[GAIN_W-1:0];
        REG_DERIV_GAIN:   deriv_gain_r <= cfg_wdata[GAIN_W-1:0];
        REG_HOVER_OFFSET: hover_r      <= cfg_wdata[DUTY_W-1:0];
        REG_DUTY_FLOOR:   floor_r      <= cfg_wdata[DUTY_W-1:0];
        REG_DUTY_CEILING: ceil_r       <= cfg_wdata[DUTY_W-1:0];
        default: ;
      endcase
    end
  end

  // integral update with saturation
  always_comb begin
    integ_sum = IW'(integral_r) + IW'(s1_err_r);
    priority if (integ_sum > INTEG_MAX) begin
      integ_sat = INTEG_MAX;
    end else if (integ_sum < INTEG_MIN) begin
      integ_sat = INTEG_MIN;
    end else begin
      integ_sat = integ_sum;
    end
    integral_nxt = integ_sat[INTEGRAL_BITS-1:0];
  end

  assign deriv  = DW'(s1_err_r) - DW'(last_err_r);
  assign p_prod = $signed({1'b0, prop_gain_r}) * s1_err_r;
  assign i_prod = $signed({1'b0, integ_gain_r}) * integral_nxt;
  assign d_prod = $signed({1'b0, deriv_gain_r}) * deriv;

  // sum, truncate toward zero, add hover offset, clamp
  always_comb begin
    pid_sum   = SW'(p_prod) + SW'(i_prod) + SW'(d_prod);
    sum_adj   = pid_sum + (pid_sum[SW-1] ? FRAC_MASK : '0);
    pid_int   = sum_adj >>> GAIN_FRAC_BITS;
    raw_duty  = pid_int + SW'($signed({1'b0, hover_r}));
    floor_ext = SW'($signed({1'b0, floor_r}));
    ceil_ext  = SW'($signed({1'b0, ceil_r}));
    // ceiling tested first; crossed limits give ceiling above it, else floor
    priority if (raw_duty > ceil_ext) begin
      out_duty_nxt    = ceil_r;
      out_clamped_nxt = 1'b1;
    end else if (raw_duty < floor_ext) begin
      out_duty_nxt    = floor_r;
      out_clamped_nxt = 1'b1;
    end else begin
      out_duty_nxt    = raw_duty[DUTY_W-1:0];
      out_clamped_nxt = 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s1_valid_r  <= 1'b0;
      out_valid_r <= 1'b0;
      integral_r  <= '0;
      last_err_r  <= '0;
    end else begin
      if (in_ch.valid && in_ch.ready) begin
        s1_valid_r <= 1'b1;
      end else if (advance) begin
        s1_valid_r <= 1'b0;
      end
      if (advance) begin
        out_valid_r <= 1'b1;
        integral_r  <= integral_nxt;
        last_err_r  <= s1_err_r;
      end else if (out_ch.ready) begin
        out_valid_r <= 1'b0;
      end
    end
  end

  // payload registers
  always_ff @(posedge clk) begin
    if (in_ch.valid && in_ch.ready) begin
      s1_err_r <= in_ch.error_sample;
    end
    if (advance) begin
      out_duty_r    <= out_duty_nxt;
      out_clamped_r <= out_clamped_nxt;
    end
  end

endmodule

// ===== src/pdc_checker.sv =====
// ----------------------------------------------------------------------------
// pdc_checker
// Port-level checks for the PID duty controller, bound into pid_duty_controller_unit.
// ----------------------------------------------------------------------------
module pdc_checker
  import pdc_pkg::*;
(
  input logic  clk,
  input logic  rst_n,
  input logic  in_valid,
  input logic  in_ready,
  input logic  out_valid,
  input logic  out_ready,
  input duty_t out_duty_percent,
  input logic  out_was_clamped
);

  // a stalled result holds
  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !out_ready |=> out_valid && $stable(out_duty_percent)
      && $stable(out_was_clamped))
    else $error("result changed while stalled");

  // a fresh result comes from a sample accepted through the input register
  a_out_origin: assert property (@(posedge clk) disable iff (!rst_n)
    $rose(out_valid) |-> $past(in_valid && in_ready, 2))
    else $error("result without a matching sample");

  // an empty output never blocks the input
  a_in_ready: assert property (@(posedge clk) disable iff (!rst_n)
    !out_valid |-> in_ready)
    else $error("input stalled with empty output");

  // reset empties the output
  a_rst_empty: assert property (@(posedge clk)
    !rst_n |=> !out_valid)
    else $error("result present after reset");

endmodule

bind pid_duty_controller_unit pdc_checker u_pdc_checker (
  .clk              (clk),
  .rst_n            (rst_n),
  .in_valid         (in_ch.valid),
  .in_ready         (in_ch.ready),
  .out_valid        (out_ch.valid),
  .out_ready        (out_ch.ready),
  .out_duty_percent (out_ch.duty_percent),
  .out_was_clamped  (out_ch.was_clamped)
);

// ===== dv/testbench.sv =====
// ----------------------------------------------------------------------------
// testbench
// Self-checking bench for pid_duty_controller_unit. Error samples go in over
// the input channel in bursts while the result channel stalls on its own
// pattern. Each accepted sample advances a local copy of the integral and
// previous error to forecast the duty and clamp flag, and each result transfer
// is compared against the oldest forecast. Covers extreme samples, floor above
// ceiling, out-of-range limits and spare indexes.
// ----------------------------------------------------------------------------
module testbench
  import pdc_pkg::*;
;
  timeunit 1ns;
  timeprecision 1ps;

  localparam int ERR_W       = ERROR_BITS_DEF;
  localparam int INTEG_W     = INTEGRAL_BITS_DEF;
  localparam int FRAC_W      = GAIN_FRAC_BITS_DEF;
  localparam int CYCLE_LIMIT = 1000000;
  localparam int HOLD_CYCLES = 80;
  localparam int SETTLE      = 4;
  localparam int SETTINGS_N  = 8;
  localparam int PHASE_ITEMS = 88;

  // indexes outside the register map, writes there must change nothing
  localparam logic [CFG_IDX_W-1:0] CFG_SPARE_LO = 3'd6;
  localparam logic [CFG_IDX_W-1:0] CFG_SPARE_HI = 3'd7;

  typedef logic signed [ERR_W-1:0]   err_t;
  typedef logic signed [INTEG_W-1:0] integ_t;

  localparam err_t ERR_MAX = {1'b0, {(ERR_W-1){1'b1}}};
  localparam err_t ERR_MIN = {1'b1, {(ERR_W-1){1'b0}}};

  typedef struct packed {
    duty_t duty;
    logic  clamped;
  } duty_word_t;

  typedef enum int {RX_FLOW, RX_COIN, RX_MOSTLY, RX_PERIODIC} rx_mode_t;

  class duty_forecast;
    gain_t  kp, ki, kd;
    duty_t  hover, lo_lim, hi_lim;
    err_t   prev_err;
    integ_t integ;
    duty_word_t due_q[$];
    int unsigned n_err, n_duty, n_clamped, n_bad, n_rail_hi, n_rail_lo;

    function new();
      kp = PROP_GAIN_RST;
      ki = INTEG_GAIN_RST;
      kd = DERIV_GAIN_RST;
      hover = HOVER_OFFSET_RST;
      lo_lim = DUTY_FLOOR_RST;
      hi_lim = DUTY_CEILING_RST;
      prev_err = '0;
      integ = '0;
    endfunction

    function void write_reg(logic [CFG_IDX_W-1:0] idx, logic [CFG_DATA_W-1:0] val);
      case (idx)
        REG_PROP_GAIN:    kp = val;
        REG_INTEG_GAIN:   ki = val;
        REG_DERIV_GAIN:   kd = val;
        REG_HOVER_OFFSET: hover = val[DUTY_W-1:0];
        REG_DUTY_FLOOR:   lo_lim = val[DUTY_W-1:0];
        REG_DUTY_CEILING: hi_lim = val[DUTY_W-1:0];
        default: ;
      endcase
    endfunction

    function void note_error(err_t e);
      longint rail_hi, rail_lo, acc, sum, whole, raw;
      duty_word_t w;
      rail_hi = (longint'(1) <<< (INTEG_W - 1)) - 1;
      rail_lo = -rail_hi - 1;
      acc = longint'(integ) + longint'(e);
      if (acc > rail_hi) begin
        acc = rail_hi;
        n_rail_hi++;
      end else if (acc < rail_lo) begin
        acc = rail_lo;
        n_rail_lo++;
      end
      sum = longint'(kp) * longint'(e) + longint'(ki) * acc
          + longint'(kd) * (longint'(e) - longint'(prev_err));
      // drop the gain fraction, rounding toward zero
      whole = (sum < 0) ? -((-sum) >>> FRAC_W) : (sum >>> FRAC_W);
      raw = whole + longint'(hover);
      // ceiling tested first; crossed limits give ceiling above it, else floor
      if (raw > longint'(hi_lim)) begin
        w.duty = hi_lim;
        w.clamped = 1'b1;
      end else if (raw < longint'(lo_lim)) begin
        w.duty = lo_lim;
        w.clamped = 1'b1;
      end else begin
        w.duty = duty_t'(raw);
        w.clamped = 1'b0;
      end
      integ = integ_t'(acc);
      prev_err = e;
      n_err++;
      if (w.clamped) n_clamped++;
      due_q.push_back(w);
    endfunction

    function void flag(string what, duty_word_t want, duty_word_t got);
      n_bad++;
      if (n_bad <= 10)
        $display("%0t: %s: expected duty %0d clamp %0b, got duty %0d clamp %0b",
                 $time, what, want.duty, want.clamped, got.duty, got.clamped);
    endfunction

    function void check_duty(duty_t d, logic c);
      duty_word_t got, want;
      got.duty = d;
      got.clamped = c;
      n_duty++;
      if (due_q.size() == 0) begin
        flag("result with nothing pending", '0, got);
      end else begin
        want = due_q.pop_front();
        if (want.duty !== got.duty || want.clamped !== got.clamped)
          flag("duty mismatch", want, got);
      end
    endfunction

    function int pending();
      return due_q.size();
    endfunction
  endclass

  logic clk;
  logic rst_n;
  logic cfg_wr_en;
  logic [CFG_IDX_W-1:0]  cfg_index;
  logic [CFG_DATA_W-1:0] cfg_wdata;

  pdc_in_if #(.ERROR_BITS(ERR_W)) in_ch ();
  pdc_out_if out_ch ();

  pid_duty_controller_unit dut (
    .clk      (clk),
    .rst_n    (rst_n),
    .in_ch    (in_ch),
    .out_ch   (out_ch),
    .cfg_wr_en(cfg_wr_en),
    .cfg_index(cfg_index),
    .cfg_wdata(cfg_wdata)
  );

  duty_forecast fc = new();

  int   burst_left = 0;
  bit   steady = 1'b0;
  bit   hold_req = 1'b0;
  err_t run_err = '0;
  int   n_settings = 0;
  int   cycles = 0;

  initial begin
    clk = 1'b0;
    forever #10 clk = ~clk;
  end

  initial begin
    while (cycles < CYCLE_LIMIT) begin
      @(posedge clk);
      cycles++;
    end
    $display("no progress after %0d cycles, %0d results still due", cycles, fc.pending());
    $display("pid_duty_controller_unit: mismatch");
    $finish;
  end

  // result side: stalls on a pattern of its own, plus a long hold-off on request
  initial begin
    rx_mode_t mode;
    int left, hold;
    out_ch.ready = 1'b0;
    mode = RX_FLOW;
    left = 0;
    hold = 0;
    forever begin
      @(negedge clk);
      if (hold_req) begin
        hold_req = 1'b0;
        hold = HOLD_CYCLES;
      end
      if (hold > 0) begin
        hold--;
        out_ch.ready <= 1'b0;
      end else begin
        if (left == 0) begin
          mode = rx_mode_t'($urandom_range(0, 3));
          left = $urandom_range(8, 60);
        end
        left--;
        case (mode)
          RX_FLOW:   out_ch.ready <= 1'b1;
          RX_COIN:   out_ch.ready <= ($urandom_range(0, 1) == 1);
          RX_MOSTLY: out_ch.ready <= ($urandom_range(0, 4) != 0);
          default:   out_ch.ready <= (left % 3 == 0);
        endcase
      end
    end
  end

  initial begin
    forever begin
      @(posedge clk);
      if (rst_n === 1'b1 && out_ch.valid === 1'b1 && out_ch.ready === 1'b1)
        fc.check_duty(out_ch.duty_percent, out_ch.was_clamped);
    end
  end

  task automatic send_error(input err_t e);
    int gap;
    @(negedge clk);
    if (burst_left == 0) begin
      burst_left = $urandom_range(1, 24);
      gap = (steady || $urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 6);
      if (gap > 0) begin
        in_ch.valid <= 1'b0;
        repeat (gap) @(negedge clk);
      end
    end
    burst_left--;
    in_ch.valid <= 1'b1;
    in_ch.error_sample <= e;
    do @(posedge clk); while (in_ch.ready !== 1'b1);
    fc.note_error(e);
  endtask

  task automatic stop_offer();
    @(negedge clk);
    in_ch.valid <= 1'b0;
    burst_left = 0;
  endtask

  task automatic wait_idle();
    while (fc.pending() != 0) @(posedge clk);
    repeat (SETTLE) @(posedge clk);
  endtask

  task automatic cfg_write(input logic [CFG_IDX_W-1:0] idx,
                           input logic [CFG_DATA_W-1:0] val);
    @(negedge clk);
    cfg_wr_en <= 1'b1;
    cfg_index <= idx;
    cfg_wdata <= val;
    @(negedge clk);
    cfg_wr_en <= 1'b0;
    fc.write_reg(idx, val);
  endtask

  // 7-bit registers get junk in the upper data bits, which must be dropped
  task automatic write_limits(input duty_t hov, input duty_t lo, input duty_t hi);
    cfg_write(REG_HOVER_OFFSET, {9'($urandom()), hov});
    cfg_write(REG_DUTY_FLOOR, {9'($urandom()), lo});
    cfg_write(REG_DUTY_CEILING, {9'($urandom()), hi});
  endtask

  task automatic write_gains(input gain_t p, input gain_t i, input gain_t d);
    cfg_write(REG_PROP_GAIN, p);
    cfg_write(REG_INTEG_GAIN, i);
    cfg_write(REG_DERIV_GAIN, d);
    n_settings++;
  endtask

  task automatic apply_setting(input int k);
    gain_t p, i, d;
    duty_t hov, lo, hi;
    if (k == 0) begin
      write_gains('1, '1, '1);
      write_limits('1, '0, '1);
    end else if (k == 1) begin
      write_gains('0, '0, '0);
      write_limits('0, '0, '0);
    end else begin
      p = ($urandom_range(0, 1) == 1) ? gain_t'($urandom_range(0, 12288)) : gain_t'($urandom());
      i = ($urandom_range(0, 1) == 1) ? gain_t'($urandom_range(0, 256)) : gain_t'($urandom());
      d = ($urandom_range(0, 1) == 1) ? gain_t'($urandom_range(0, 8192)) : gain_t'($urandom());
      hov = duty_t'($urandom_range(0, 127));
      if ($urandom_range(0, 3) == 0) begin
        lo = duty_t'($urandom_range(0, 127));
        hi = duty_t'($urandom_range(0, 127));
      end else begin
        lo = duty_t'($urandom_range(0, 50));
        hi = duty_t'($urandom_range(50, 127));
      end
      write_gains(p, i, d);
      write_limits(hov, lo, hi);
      if ($urandom_range(0, 1) == 1)
        cfg_write($urandom_range(0, 1) ? CFG_SPARE_LO : CFG_SPARE_HI, 16'($urandom()));
    end
  endtask

  function automatic err_t pick_error();
    int v;
    case ($urandom_range(0, 9))
      0, 1, 2, 3: v = int'($urandom_range(0, 80)) - 40;
      4, 5:       v = int'(err_t'($urandom()));
      6:          v = $urandom_range(0, 1) ? int'(ERR_MAX) : int'(ERR_MIN);
      7:          v = int'($urandom_range(0, 1000)) - 500;
      default:    v = int'(run_err);  // repeated sample, zero derivative
    endcase
    run_err = err_t'(v);
    return err_t'(v);
  endfunction

  initial begin
    rst_n = 1'b0;
    in_ch.valid = 1'b0;
    in_ch.error_sample = '0;
    cfg_wr_en = 1'b0;
    cfg_index = '0;
    cfg_wdata = '0;
    repeat (8) @(posedge clk);
    @(negedge clk);
    rst_n <= 1'b1;

    // reset values: zero, unit steps, both extremes, repeats for zero derivative
    send_error('0);
    send_error(err_t'(1));
    send_error(err_t'(-1));
    send_error(ERR_MAX);
    send_error(ERR_MAX);
    send_error(ERR_MIN);
    send_error(ERR_MIN);
    send_error('0);
    send_error(err_t'(5));
    send_error(err_t'(-5));
    send_error(err_t'(100));
    send_error(err_t'(-100));
    stop_offer();
    wait_idle();

    // derivative path alone at full gain
    write_gains('0, '0, '1);
    send_error(ERR_MAX);
    send_error(ERR_MIN);
    send_error(ERR_MAX);
    send_error('0);
    stop_offer();
    wait_idle();

    // floor above ceiling; spare indexes must not disturb anything
    write_gains(PROP_GAIN_RST, INTEG_GAIN_RST, DERIV_GAIN_RST);
    write_limits(HOVER_OFFSET_RST, duty_t'(80), duty_t'(30));
    cfg_write(CFG_SPARE_LO, '1);
    cfg_write(CFG_SPARE_HI, '1);
    send_error('0);
    send_error(ERR_MAX);
    send_error(ERR_MIN);
    send_error('0);
    stop_offer();
    wait_idle();

    for (int k = 0; k < SETTINGS_N; k++) begin
      apply_setting(k);
      steady = (k == 0 || k == 4);
      if (steady) hold_req = 1'b1;
      repeat (PHASE_ITEMS) send_error(pick_error());
      stop_offer();
      wait_idle();
    end

    $display("covered %0d samples and %0d results (%0d clamped) over %0d gain settings",
             fc.n_err, fc.n_duty, fc.n_clamped, n_settings);
    $display("integral held at its upper rail %0d times, at its lower rail %0d times",
             fc.n_rail_hi, fc.n_rail_lo);
    if (fc.n_bad == 0 && fc.pending() == 0) begin
      $display("pid_duty_controller_unit: match");
    end else begin
      $display("%0d bad results", fc.n_bad);
      $display("pid_duty_controller_unit: mismatch");
    end
    $finish;
  end

endmodule

// ===== files.f =====
src/pdc_pkg.sv
src/pdc_in_if.sv
src/pdc_out_if.sv
src/pid_duty_controller_unit.sv
src/pdc_checker.sv
dv/testbench.sv
